// ===== design/tst_pkg.sv =====
// Shared types, constants and codes for the timer slot table.
package tst_pkg;

    localparam int SLOT_COUNT = 128;
    localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = SLOT_AW + 1;

    localparam int ID_W     = 31;
    localparam int NS_W     = 64;
    localparam int REP_W    = 32;
    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 40;

    localparam logic [1:0] FUNC_POLL   = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    typedef struct packed {
        logic              done;
        logic [REP_W-1:0]  repeat_count;
        logic [NS_W-1:0]   accum;
        logic [NS_W-1:0]   period;
        logic [ID_W-1:0]   ident;
    } slot_rec_t;

    localparam int REC_W = $bits(slot_rec_t);

    typedef enum logic [2:0] {
        OP_CREATE,
        OP_POLL,
        OP_DELETE,
        OP_TICK,
        OP_NONE
    } op_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

endpackage

// ===== design/tst_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module tst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/timer_slot_table_top.sv =====
// Top level of the timer slot table: control, slot scan pipeline and item ports.
//
// The block keeps a bank of timer slots in one RAM, one record per slot.
// An input item arrives on the s_ channel: s_tuser carries the operation
// (poll or create, delete, tick) and s_tdata carries the id, the time amount
// and the repeat count. Every accepted item gives exactly one result item on
// the m_ channel with the fired, assigned id, found and table full flags.
// Each operation walks the slots in order through a read, add and
// compare/write pipeline, one slot per cycle, limited by the single RAM read
// port. A tick walks every slot before it gives its result.
// A create, poll or delete ends at the first matching slot, or after the
// last slot when no slot matches. An unused operation code skips the scan.
// One item is worked on at a time; s_tready is high while the block waits
// for an item, even when a result is still held. If the receiver stalls, the
// result stays in the output register and a finished scan waits until that
// register is free. Reset clears the slot valid bits, so every slot reads as
// free, and sets the id counter to one. No clearing pass is needed.
module timer_slot_table_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // timer_id[30:0], amount_ns[94:31], repeat_count[126:95], zero[127]
    input  logic [tst_pkg::S_DATA_W-1:0] s_tdata,
    // func[1:0]
    input  logic [1:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // fired[0], assigned_id[31:1], found[32], table_full[33], zero[39:34]
    output logic [tst_pkg::M_DATA_W-1:0] m_tdata
);

    localparam logic [tst_pkg::CNT_W-1:0] SLOT_END = tst_pkg::CNT_W'(tst_pkg::SLOT_COUNT);

    tst_pkg::state_t state_reg, state_next;

    tst_pkg::op_kind_t              op_reg, op_next;
    logic [tst_pkg::ID_W-1:0]       op_id_reg;
    logic [tst_pkg::NS_W-1:0]       op_amount_reg;
    logic [tst_pkg::REP_W-1:0]      op_rep_reg;
    logic [tst_pkg::ID_W-1:0]       op_nid_reg;
    logic [tst_pkg::ID_W-1:0]       next_ident_reg, next_ident_next;

    logic [tst_pkg::CNT_W-1:0]      rd_cnt_reg;
    logic                           p0_vld_reg;
    logic                           p0_bit_reg;
    logic [tst_pkg::SLOT_AW-1:0]    p0_addr_reg;
    logic                           p1_vld_reg;
    logic                           p1_hit_reg;
    logic [tst_pkg::SLOT_AW-1:0]    p1_addr_reg;
    tst_pkg::slot_rec_t             p1_rec_reg;
    logic [tst_pkg::SLOT_COUNT-1:0] slot_vld_reg;

    logic                           res_found_reg;
    logic                           res_fired_reg;
    logic                           m_tvalid_reg;
    logic [tst_pkg::M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                           accept;
    logic                           scan_start;
    logic                           rd_issue;
    logic                           out_load;
    logic                           scan_done;
    logic [tst_pkg::SLOT_AW-1:0]    rd_addr;

    logic [tst_pkg::ID_W-1:0]       in_id;
    logic [tst_pkg::REP_W-1:0]      in_rep;
    logic [tst_pkg::NS_W-1:0]       in_amount;

    logic [tst_pkg::REC_W-1:0]      ram_rdata;
    tst_pkg::slot_rec_t             s1_rec;
    tst_pkg::slot_rec_t             s1_new;
    logic                           s1_occ;
    logic                           s1_hit;
    logic                           s1_add;
    logic [tst_pkg::NS_W:0]         s1_sum;

    tst_pkg::slot_rec_t             s2_rec;
    logic                           s2_we;
    logic                           first_hit;

    assign in_id     = s_tdata[30:0];
    assign in_amount = s_tdata[94:31];
    assign in_rep    = s_tdata[126:95];

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == tst_pkg::ST_IDLE);
    assign rd_issue = (state_reg == tst_pkg::ST_SCAN) && (rd_cnt_reg < SLOT_END);
    assign rd_addr  = rd_cnt_reg[tst_pkg::SLOT_AW-1:0];
    assign out_load = (state_reg == tst_pkg::ST_RESULT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        op_next = tst_pkg::OP_NONE;
        case (s_tuser)
            tst_pkg::FUNC_POLL: begin
                op_next = (in_id == '0) ? tst_pkg::OP_CREATE : tst_pkg::OP_POLL;
            end
            tst_pkg::FUNC_DELETE: op_next = tst_pkg::OP_DELETE;
            tst_pkg::FUNC_TICK:   op_next = tst_pkg::OP_TICK;
            default:              op_next = tst_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        next_ident_next = next_ident_reg;
        if (accept && (op_next == tst_pkg::OP_CREATE)) begin
            next_ident_next = next_ident_reg + 1'b1;
            if (next_ident_next == '0) begin
                next_ident_next = tst_pkg::ID_W'(1);
            end
        end
    end

    tst_ram #(
        .WIDTH (tst_pkg::REC_W),
        .DEPTH (tst_pkg::SLOT_COUNT)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (s2_we),
        .waddr (p1_addr_reg),
        .wdata (s2_rec),
        .re    (rd_issue),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb begin
        s1_rec = p0_bit_reg ? tst_pkg::slot_rec_t'(ram_rdata) : '0;
        s1_occ = (s1_rec.ident != '0);
        s1_add = (s1_rec.repeat_count != '0);
        s1_sum = {1'b0, s1_rec.accum} + {1'b0, op_amount_reg};
        s1_new = s1_rec;
        s1_hit = 1'b0;
        case (op_reg) inside
            tst_pkg::OP_CREATE: s1_hit = !s1_occ;
            tst_pkg::OP_POLL,
            tst_pkg::OP_DELETE: s1_hit = s1_occ && (s1_rec.ident == op_id_reg);
            tst_pkg::OP_TICK: begin
                s1_hit = s1_occ;
                if (!s1_rec.repeat_count[tst_pkg::REP_W-1] && s1_add) begin
                    s1_new.repeat_count = s1_rec.repeat_count - 1'b1;
                end
                if (s1_add) begin
                    s1_new.accum = s1_sum[tst_pkg::NS_W] ? '1 : s1_sum[tst_pkg::NS_W-1:0];
                end
            end
            default: s1_hit = 1'b0;
        endcase
    end

    assign first_hit = p1_vld_reg && p1_hit_reg && !res_found_reg;

    always_comb begin
        s2_rec = p1_rec_reg;
        s2_we  = 1'b0;
        case (op_reg)
            tst_pkg::OP_TICK: begin
                s2_we = p1_vld_reg && p1_hit_reg;
                if (p1_rec_reg.accum >= p1_rec_reg.period) begin
                    s2_rec.accum = p1_rec_reg.accum - p1_rec_reg.period;
                    s2_rec.done  = 1'b1;
                end
            end
            tst_pkg::OP_CREATE: begin
                s2_we               = first_hit;
                s2_rec              = '0;
                s2_rec.ident        = op_nid_reg;
                s2_rec.period       = op_amount_reg;
                s2_rec.repeat_count = op_rep_reg;
            end
            tst_pkg::OP_POLL: begin
                s2_we       = first_hit;
                s2_rec.done = 1'b0;
            end
            tst_pkg::OP_DELETE: begin
                s2_we  = first_hit;
                s2_rec = '0;
            end
            default: s2_we = 1'b0;
        endcase
    end

    assign scan_done = ((op_reg != tst_pkg::OP_TICK) && first_hit)
                    || ((rd_cnt_reg == SLOT_END) && !p0_vld_reg && !p1_vld_reg);

    assign scan_start = accept && (op_next != tst_pkg::OP_NONE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tst_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = scan_start ? tst_pkg::ST_SCAN : tst_pkg::ST_RESULT;
                end
            end
            tst_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = tst_pkg::ST_RESULT;
                end
            end
            tst_pkg::ST_RESULT: begin
                if (out_load) begin
                    state_next = tst_pkg::ST_IDLE;
                end
            end
            default: state_next = tst_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        m_tdata_next       = '0;
        m_tdata_next[0]    = res_fired_reg;
        m_tdata_next[31:1] = (op_reg == tst_pkg::OP_CREATE) ? op_nid_reg : '0;
        m_tdata_next[32]   = res_found_reg;
        m_tdata_next[33]   = (op_reg == tst_pkg::OP_CREATE) && !res_found_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tst_pkg::ST_IDLE;
            op_reg         <= tst_pkg::OP_NONE;
            next_ident_reg <= tst_pkg::ID_W'(1);
            rd_cnt_reg     <= '0;
            p0_vld_reg     <= 1'b0;
            p1_vld_reg     <= 1'b0;
            slot_vld_reg   <= '0;
            res_found_reg  <= 1'b0;
            res_fired_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            next_ident_reg <= next_ident_next;
            p0_vld_reg     <= rd_issue;
            p1_vld_reg     <= p0_vld_reg && (state_reg == tst_pkg::ST_SCAN) && !scan_done;
            if (accept) begin
                op_reg        <= op_next;
                rd_cnt_reg    <= '0;
                res_found_reg <= 1'b0;
                res_fired_reg <= 1'b0;
            end else if (rd_issue) begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            if (first_hit && (op_reg != tst_pkg::OP_TICK)) begin
                res_found_reg <= 1'b1;
                res_fired_reg <= (op_reg == tst_pkg::OP_POLL) && p1_rec_reg.done;
            end
            if (s2_we) begin
                slot_vld_reg[p1_addr_reg] <= 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_id_reg     <= in_id;
            op_amount_reg <= in_amount;
            op_rep_reg    <= in_rep;
            op_nid_reg    <= next_ident_reg;
        end
        p0_addr_reg <= rd_addr;
        p0_bit_reg  <= slot_vld_reg[rd_addr];
        p1_addr_reg <= p0_addr_reg;
        p1_rec_reg  <= s1_new;
        p1_hit_reg  <= s1_hit;
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != tst_pkg::ST_SCAN) |-> !s2_we)
        else $error("slot RAM written outside a scan");

    a_ident_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        next_ident_reg != '0)
        else $error("id counter reached zero");

    a_full_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tdata_reg[33] && m_tdata_reg[32]))
        else $error("result flags table full and found together");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("second item taken while one is in work");

endmodule

// ===== bench/tb_timer_slot_table_top.sv =====
// Self-checking testbench for the timer slot table with a slot-level predictor.
module tb_timer_slot_table_top;

    localparam logic [1:0]               FUNC_UNUSED    = 2'd3;
    localparam logic [tst_pkg::ID_W-1:0] ID_MAX         = {tst_pkg::ID_W{1'b1}};
    localparam int                       RANDOM_ITEMS   = 1380;
    localparam int                       STALL_LIMIT    = 6000;
    localparam int                       HOLD_CYCLES    = 1000;
    localparam int                       HOLD_AT_FIRST  = 200;
    localparam int                       HOLD_AT_SECOND = 1150;
    localparam int                       DRAIN_CYCLES   = tst_pkg::SLOT_COUNT + 20;

    typedef struct packed {
        logic                     table_full;
        logic                     found;
        logic [tst_pkg::ID_W-1:0] assigned_id;
        logic                     fired;
    } timer_reply_t;

    localparam int REPLY_W = $bits(timer_reply_t);

    typedef enum int {
        K_CREATE,
        K_POLL_LIVE,
        K_POLL_STRAY,
        K_DELETE_LIVE,
        K_DELETE_STRAY,
        K_TICK,
        K_UNUSED
    } stim_kind_t;

    // Cumulative percentages per traffic mix: filling, draining, balanced.
    localparam int OP_MIX [3][7] = '{
        '{60, 75, 78, 83, 85, 97, 100},
        '{5, 20, 23, 70, 75, 95, 100},
        '{22, 47, 52, 67, 70, 95, 100}
    };

    class timer_scoreboard;
        logic [tst_pkg::ID_W-1:0]         ident        [tst_pkg::SLOT_COUNT];
        logic [tst_pkg::NS_W-1:0]         period       [tst_pkg::SLOT_COUNT];
        logic [tst_pkg::NS_W-1:0]         accum        [tst_pkg::SLOT_COUNT];
        logic signed [tst_pkg::REP_W-1:0] repeats_left [tst_pkg::SLOT_COUNT];
        logic                             done         [tst_pkg::SLOT_COUNT];
        logic [tst_pkg::ID_W-1:0]         next_id;
        timer_reply_t                     expected_replies[$];
        int                               errors;

        function new();
            for (int i = 0; i < tst_pkg::SLOT_COUNT; i++) clear_slot(i);
            next_id = tst_pkg::ID_W'(1);
            errors  = 0;
        endfunction

        function void clear_slot(int i);
            ident[i]        = '0;
            period[i]       = '0;
            accum[i]        = '0;
            repeats_left[i] = '0;
            done[i]         = 1'b0;
        endfunction

        function int find_slot(logic [tst_pkg::ID_W-1:0] id);
            if (id == '0) return -1;
            for (int i = 0; i < tst_pkg::SLOT_COUNT; i++)
                if (ident[i] == id) return i;
            return -1;
        endfunction

        function void tick_all(logic [tst_pkg::NS_W-1:0] elapsed);
            logic [tst_pkg::NS_W:0] sum;
            for (int i = 0; i < tst_pkg::SLOT_COUNT; i++) begin
                if (ident[i] == '0) continue;
                if (repeats_left[i] != 0) begin
                    sum      = {1'b0, accum[i]} + {1'b0, elapsed};
                    accum[i] = sum[tst_pkg::NS_W] ? {tst_pkg::NS_W{1'b1}}
                                                  : sum[tst_pkg::NS_W-1:0];
                    if (repeats_left[i] > 0) repeats_left[i] = repeats_left[i] - 1;
                end
                if (accum[i] >= period[i]) begin
                    accum[i] = accum[i] - period[i];
                    done[i]  = 1'b1;
                end
            end
        endfunction

        function void note_item(logic [1:0] func, logic [tst_pkg::ID_W-1:0] id,
                                logic [tst_pkg::NS_W-1:0] amount,
                                logic [tst_pkg::REP_W-1:0] rep);
            timer_reply_t reply;
            int           slot;
            reply = '0;
            case (func)
                tst_pkg::FUNC_POLL: begin
                    if (id == '0) begin
                        reply.assigned_id = next_id;
                        next_id = next_id + 1'b1;
                        if (next_id == '0) next_id = tst_pkg::ID_W'(1);
                        slot = -1;
                        for (int i = 0; i < tst_pkg::SLOT_COUNT; i++)
                            if (slot < 0 && ident[i] == '0) slot = i;
                        if (slot < 0) begin
                            reply.table_full = 1'b1;
                        end else begin
                            clear_slot(slot);
                            ident[slot]        = reply.assigned_id;
                            period[slot]       = amount;
                            repeats_left[slot] = rep;
                            reply.found        = 1'b1;
                        end
                    end else begin
                        slot = find_slot(id);
                        if (slot >= 0) begin
                            reply.found = 1'b1;
                            reply.fired = done[slot];
                            done[slot]  = 1'b0;
                        end
                    end
                end
                tst_pkg::FUNC_DELETE: begin
                    slot = find_slot(id);
                    if (slot >= 0) begin
                        reply.found = 1'b1;
                        clear_slot(slot);
                    end
                end
                tst_pkg::FUNC_TICK: tick_all(amount);
                default: ;
            endcase
            expected_replies.push_back(reply);
        endfunction

        function void report(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_result(logic [tst_pkg::M_DATA_W-1:0] data);
            timer_reply_t want;
            timer_reply_t got;
            if (expected_replies.size() == 0) begin
                errors++;
                $display("%0t: result %0h arrived, expected none", $time, data);
                return;
            end
            want = expected_replies.pop_front();
            got  = data[REPLY_W-1:0];
            report("fired", 64'(want.fired), 64'(got.fired));
            report("assigned_id", 64'(want.assigned_id), 64'(got.assigned_id));
            report("found", 64'(want.found), 64'(got.found));
            report("table_full", 64'(want.table_full), 64'(got.table_full));
            report("padding", '0, 64'(data[tst_pkg::M_DATA_W-1:REPLY_W]));
        endfunction

        function logic [tst_pkg::ID_W-1:0] live_id();
            int start;
            int s;
            start = $urandom_range(tst_pkg::SLOT_COUNT - 1);
            for (int k = 0; k < tst_pkg::SLOT_COUNT; k++) begin
                s = (start + k) % tst_pkg::SLOT_COUNT;
                if (ident[s] != '0) return ident[s];
            end
            return '0;
        endfunction
    endclass

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [tst_pkg::S_DATA_W-1:0]   s_tdata  = '0;
    logic [1:0]                     s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [tst_pkg::M_DATA_W-1:0]   m_tdata;

    timer_scoreboard timers;
    int send_idle_pct = 38;
    int recv_idle_pct = 50;
    int items_sent    = 0;
    int quiet_cycles  = 0;
    int hold_left     = 0;
    int holds_done    = 0;

    timer_slot_table_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (hold_left == 0 && holds_done < 2 &&
            items_sent >= (holds_done == 0 ? HOLD_AT_FIRST : HOLD_AT_SECOND)) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) timers.check_result(m_tdata);
            if (s_tvalid && s_tready)
                timers.note_item(s_tuser, s_tdata[tst_pkg::ID_W-1:0],
                                 s_tdata[tst_pkg::ID_W +: tst_pkg::NS_W],
                                 s_tdata[tst_pkg::ID_W+tst_pkg::NS_W +: tst_pkg::REP_W]);
        end
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [tst_pkg::ID_W-1:0] rand_id();
        return tst_pkg::ID_W'($urandom);
    endfunction

    function automatic logic [tst_pkg::NS_W-1:0] rand_period();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return rand64();
            3:       return tst_pkg::NS_W'($urandom_range(1, 10));
            default: return tst_pkg::NS_W'($urandom_range(1, 3000));
        endcase
    endfunction

    function automatic logic [tst_pkg::NS_W-1:0] rand_elapsed();
        case ($urandom_range(19))
            0:       return '0;
            1:       return '1;
            2:       return rand64();
            default: return tst_pkg::NS_W'($urandom_range(0, 1500));
        endcase
    endfunction

    function automatic logic [tst_pkg::REP_W-1:0] rand_repeat();
        logic [tst_pkg::REP_W-1:0] v;
        v = tst_pkg::REP_W'($urandom_range(1, 5));
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            3:       return 32'h8000_0000;
            4:       return 32'h7fff_ffff;
            5, 6:    return -v;
            default: return tst_pkg::REP_W'($urandom_range(1, 20));
        endcase
    endfunction

    function automatic logic [tst_pkg::ID_W-1:0] stray_id();
        logic [tst_pkg::ID_W-1:0] id;
        id = rand_id();
        if ($urandom_range(1) == 0)
            id = timers.next_id + tst_pkg::ID_W'($urandom_range(0, 3));
        return (id == '0) ? ID_MAX : id;
    endfunction

    task automatic issue_op(input logic [1:0] func, input logic [tst_pkg::ID_W-1:0] id,
                            input logic [tst_pkg::NS_W-1:0] amount,
                            input logic [tst_pkg::REP_W-1:0] rep);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {1'b0, rep, amount, id};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic create_timer(input logic [tst_pkg::NS_W-1:0] per,
                                input logic [tst_pkg::REP_W-1:0] rep);
        issue_op(tst_pkg::FUNC_POLL, '0, per, rep);
    endtask

    task automatic poll_timer(input logic [tst_pkg::ID_W-1:0] id);
        issue_op(tst_pkg::FUNC_POLL, id, rand64(), $urandom);
    endtask

    task automatic delete_timer(input logic [tst_pkg::ID_W-1:0] id);
        issue_op(tst_pkg::FUNC_DELETE, id, rand64(), $urandom);
    endtask

    task automatic tick_timers(input logic [tst_pkg::NS_W-1:0] elapsed);
        issue_op(tst_pkg::FUNC_TICK, rand_id(), elapsed, $urandom);
    endtask

    task automatic run_directed();
        create_timer('0, '1);
        create_timer('1, 32'h7fff_ffff);
        create_timer(64'd100, '0);
        create_timer(64'd50, 32'd2);
        create_timer(64'd1, 32'h8000_0000);
        tick_timers('0);
        tick_timers('1);
        tick_timers('1);
        poll_timer(31'd1);
        poll_timer(31'd1);
        poll_timer(31'd3);
        poll_timer(ID_MAX);
        delete_timer(ID_MAX);
        delete_timer('0);
        delete_timer(31'd2);
        poll_timer(31'd2);
        create_timer(64'd7, 32'd3);
        issue_op(FUNC_UNUSED, rand_id(), rand64(), $urandom);
        issue_op(FUNC_UNUSED, ID_MAX, '1, '1);
        tick_timers(64'd60);
        poll_timer(31'd4);
        poll_timer(31'd6);
        delete_timer(31'd6);
    endtask

    task automatic run_random(input int n);
        int mode;
        int mix;
        int r;
        int k;
        mode = (n / 100) % 7;
        mix  = (mode < 3) ? 0 : (mode == 4 || mode == 5) ? 1 : 2;
        r    = $urandom_range(99);
        k    = 0;
        while (r >= OP_MIX[mix][k]) k++;
        case (k)
            K_CREATE:       create_timer(rand_period(), rand_repeat());
            K_POLL_LIVE:    poll_timer(timers.live_id());
            K_POLL_STRAY:   poll_timer(stray_id());
            K_DELETE_LIVE:  delete_timer(timers.live_id());
            K_DELETE_STRAY: delete_timer(stray_id());
            K_TICK:         tick_timers(rand_elapsed());
            default:        issue_op(FUNC_UNUSED, rand_id(), rand64(), $urandom);
        endcase
    endtask

    initial begin
        int n;
        timers = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct = 50;
                recv_idle_pct = 38;
            end
            if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_random(n);
        end
        s_tvalid <= 1'b0;
        while (timers.expected_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (timers.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
